FILE: rtl/core/wsd_pkg.sv
// Shared widths, result codes and header field types for the frame deframer.
// No dependencies; imported by the channel interfaces and the core.
package wsd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 31;
   localparam int KIND_W   = 2;
   localparam int RSV_W    = 3;
   localparam int OPCODE_W = 4;

   // Largest length a frame may carry at all
   localparam logic [LEN_W-1:0] LEN_LIMIT         = {LEN_W{1'b1}};
   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(65535);

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   // 7-bit length escapes
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   // Header flags collected from the first two header bytes
   typedef struct packed {
      logic                fin;
      logic [RSV_W-1:0]    rsv;
      logic [OPCODE_W-1:0] opcode;
      logic                masked;
   } frame_flags_type;

endpackage

FILE: rtl/core/wsd_req_if.sv
// Receive byte channel: valid/ready handshake carrying one stream byte.
// Depends on wsd_pkg.
interface wsd_req_if import wsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/wsd_rsp_if.sv
// Result channel: valid/ready handshake carrying header, payload and error results.
// Depends on wsd_pkg.
interface wsd_rsp_if import wsd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic                fin;
   logic [RSV_W-1:0]    reserved_bits;
   logic [OPCODE_W-1:0] opcode;
   logic                masked;
   logic [LEN_W-1:0]    payload_length;
   logic [BYTE_W-1:0]   data_byte;
   logic                last;

   modport source (output valid, output kind, output fin, output reserved_bits,
                   output opcode, output masked, output payload_length,
                   output data_byte, output last, input ready);
   modport sink   (input valid, input kind, input fin, input reserved_bits,
                   input opcode, input masked, input payload_length,
                   input data_byte, input last, output ready);
endinterface

FILE: rtl/core/wsd_csr_if.sv
// Configuration write channel: valid/ready handshake carrying max_payload.
// Depends on wsd_pkg.
interface wsd_csr_if import wsd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] max_payload;

   modport source (output valid, output max_payload, input ready);
   modport sink   (input valid, input max_payload, output ready);
endinterface

FILE: rtl/core/websocket_frame_deframer_core.sv
// WebSocket receive-side frame deframer core.
// Channels: req carries the received stream one byte per transaction, in wire
// order. rsp returns one header result per frame (after the last header byte,
// masking key included), then one result per payload byte, unmasked, with last
// set on the final byte (or on the header of a zero-length frame). A length
// above 2^31-1 or above max_payload gives one error result; the core then
// swallows every byte until reset. csr writes max_payload (always ready).
// A byte taken from req is held in the input register; its result, if it
// has one, moves into the output register, which drives rsp, once it is free.
// Throughput: one byte per cycle while rsp is not stalled; header bytes
// produce no result. When rsp is stalled, the output register holds its
// result, the input register holds one more byte, and req.ready drops
// until rsp takes it.
// Reset: synchronous, clears both valid bits, the parse phase and the field
// counter, and sets max_payload to 65535.
// Depends on wsd_pkg and the wsd_req_if, wsd_rsp_if and wsd_csr_if interfaces.
module websocket_frame_deframer_core import wsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   wsd_req_if.sink      req,
   wsd_rsp_if.source    rsp,
   wsd_csr_if.sink      csr
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_KEY,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   localparam logic [3:0] CNT_EXT16 = 4'd2;
   localparam logic [3:0] CNT_EXT64 = 4'd8;
   localparam logic [3:0] CNT_KEY   = 4'd4;

   // Parser state
   phase_type        phase_ff, phase_in;
   logic [3:0]       cnt_ff, cnt_in;
   frame_flags_type  flags_ff, flags_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [31:0]      key_ff, key_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [1:0]       kidx_ff, kidx_in;
   logic [LEN_W-1:0] max_payload_ff;

   // Input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Output register
   logic                out_valid_ff;
   logic [KIND_W-1:0]   out_kind_ff, out_kind_in;
   frame_flags_type     out_flags_ff;
   logic [LEN_W-1:0]    out_len_ff, out_len_in;
   logic [BYTE_W-1:0]   out_data_ff, out_data_in;
   logic                out_last_ff, out_last_in;
   logic                emit;

   logic              advance;
   logic              process;
   logic              hdr_done;
   logic [BYTE_W-1:0] key_byte;
   logic [BYTE_W-1:0] b;

   // Handshake: output register frees when empty or taken
   assign advance   = !out_valid_ff || rsp.ready;
   assign process   = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;
   assign b         = in_byte_ff;

   // Masking key byte for the current payload position
   always_comb begin
      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Per-byte parse step
   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      flags_in    = flags_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      key_in      = key_ff;
      remain_in   = remain_ff;
      kidx_in     = kidx_ff;
      emit        = 1'b0;
      hdr_done    = 1'b0;
      out_kind_in = KIND_HEADER;
      out_len_in  = len_ff;
      out_data_in = '0;
      out_last_in = 1'b0;

      if (process) begin
         case (phase_ff)
            PH_HDR0: begin
               flags_in.fin    = b[7];
               flags_in.rsv    = b[6:4];
               flags_in.opcode = b[3:0];
               flags_in.masked = 1'b0;
               phase_in        = PH_HDR1;
            end
            PH_HDR1: begin
               flags_in.masked = b[7];
               ovf_in          = 1'b0;
               if (b[6:0] == LEN7_EXT16) begin
                  len_in   = '0;
                  cnt_in   = CNT_EXT16;
                  phase_in = PH_EXTLEN;
               end else if (b[6:0] == LEN7_EXT64) begin
                  len_in   = '0;
                  cnt_in   = CNT_EXT64;
                  phase_in = PH_EXTLEN;
               end else begin
                  len_in = LEN_W'(b[6:0]);
                  if (b[7]) begin
                     cnt_in   = CNT_KEY;
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXTLEN: begin
               // bits shifted out above bit 30 mark an oversized length
               len_in = {len_ff[LEN_W-BYTE_W-1:0], b};
               ovf_in = ovf_ff | (|len_ff[LEN_W-1:LEN_W-BYTE_W]);
               cnt_in = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  if (flags_ff.masked) begin
                     cnt_in   = CNT_KEY;
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], b};
               cnt_in = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  hdr_done = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               emit        = 1'b1;
               out_kind_in = KIND_PAYLOAD;
               out_data_in = flags_ff.masked ? (b ^ key_byte) : b;
               out_last_in = (remain_ff == LEN_W'(1));
               kidx_in     = kidx_ff + 2'd1;
               remain_in   = remain_ff - LEN_W'(1);
               if (remain_ff == LEN_W'(1)) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               // halted: byte dropped
            end
         endcase

         // Header complete: length check and header or error result
         if (hdr_done) begin
            emit = 1'b1;
            if (ovf_in || (len_in > max_payload_ff)) begin
               out_kind_in = KIND_ERROR;
               out_len_in  = LEN_LIMIT;
               phase_in    = PH_HALT;
            end else begin
               out_kind_in = KIND_HEADER;
               out_len_in  = len_in;
               out_last_in = (len_in == '0);
               remain_in   = len_in;
               kidx_in     = 2'd0;
               phase_in    = (len_in == '0) ? PH_HDR0 : PH_PAYLOAD;
            end
         end
      end
   end

   // State, input register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR0;
         cnt_ff         <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         if (csr.valid && csr.ready) begin
            max_payload_ff <= csr.max_payload;
         end
         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= emit;
         end
      end
      flags_ff  <= flags_in;
      len_ff    <= len_in;
      ovf_ff    <= ovf_in;
      key_ff    <= key_in;
      remain_ff <= remain_in;
      kidx_ff   <= kidx_in;
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
      if (advance && emit) begin
         out_kind_ff  <= out_kind_in;
         out_flags_ff <= flags_in;
         out_len_ff   <= out_len_in;
         out_data_ff  <= out_data_in;
         out_last_ff  <= out_last_in;
      end
   end

   // Result channel
   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = out_kind_ff;
   assign rsp.fin            = out_flags_ff.fin;
   assign rsp.reserved_bits  = out_flags_ff.rsv;
   assign rsp.opcode         = out_flags_ff.opcode;
   assign rsp.masked         = out_flags_ff.masked;
   assign rsp.payload_length = out_len_ff;
   assign rsp.data_byte      = out_data_ff;
   assign rsp.last           = out_last_ff;

`ifndef ASSERT_OFF
   // An error result is only ever shown with the parser halted
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.kind == KIND_ERROR) |-> (phase_ff == PH_HALT))
      else $error("error result without halted parser");

   // Halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT))
      else $error("parser left halt state");

   // A payload byte that is not last leaves the parser inside the payload
   a_payload_cont: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.kind == KIND_PAYLOAD) && !rsp.last |-> (phase_ff == PH_PAYLOAD))
      else $error("payload continues but parser left payload phase");

   // Header closes the frame exactly when its length is zero
   a_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.kind == KIND_HEADER) |-> (rsp.last == (rsp.payload_length == '0)))
      else $error("header last flag disagrees with length");
`endif

endmodule
